// ----- rtl/core/gip_pkg.sv -----
package gip_pkg;

    localparam int CNT_W            = 16;
    localparam int LEN_W            = 7;
    localparam int STATUS_W         = 3;
    localparam int CFG_IDX_W        = 2;

    localparam int MIN_REPORT_BYTES = 14;

    // Transfer status codes
    localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NAK      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTREADY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STALL    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_SILENT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIPE_REOPEN_LIMIT = 2'd2;

    localparam logic [CNT_W-1:0] RETRY_LIMIT_RST       = 16'd50;
    localparam logic [CNT_W-1:0] PAD_SILENT_LIMIT_RST  = 16'd300;
    localparam logic [CNT_W-1:0] PIPE_REOPEN_LIMIT_RST = 16'd1500;

    typedef struct packed {
        logic                enumerated;
        logic                endpoint_found;
        logic [STATUS_W-1:0] xfer_status;
        logic [LEN_W-1:0]    xfer_length;
        logic [7:0]          button_low_byte;
        logic [7:0]          button_high_byte;
        logic [7:0]          left_trigger_byte;
        logic [7:0]          right_trigger_byte;
        logic [7:0]          left_y_byte;
        logic [7:0]          left_x_byte;
        logic [7:0]          right_y_byte;
        logic [7:0]          right_x_byte;
    } t_tick;

    typedef struct packed {
        logic [15:0]       buttons;
        logic [7:0]        left_trigger;
        logic [7:0]        right_trigger;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
    } t_report;

    typedef struct packed {
        logic    issue_request;
        logic    open_pipe;
        logic    pad_connected;
        t_report report;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CNT_W-1:0]     data;
    } t_cfg_wr;

endpackage

// ----- rtl/core/gip_in_reg.sv -----
// Input stage: holds one accepted tick until the engine takes it.
module gip_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gip_pkg::t_tick i_tick,
    input  logic          i_down_ready,
    output logic          o_advance,
    output gip_pkg::t_tick o_tick
);

    logic           r_valid;
    gip_pkg::t_tick r_tick;
    logic           accept;

    assign o_advance = r_valid && i_down_ready;
    assign o_stall   = r_valid && !i_down_ready;
    assign accept    = i_valid && !o_stall;
    assign o_tick    = r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tick <= i_tick;
        end
    end

endmodule

// ----- rtl/core/gip_tick_engine.sv -----
// Poller state and per-tick update; state commits when a tick advances.
module gip_tick_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gip_pkg::t_cfg_wr i_cfg,
    input  logic             i_advance,
    input  gip_pkg::t_tick   i_tick,
    output gip_pkg::t_result o_result
);

    logic [gip_pkg::CNT_W-1:0] r_retry_limit;
    logic [gip_pkg::CNT_W-1:0] r_pad_limit;
    logic [gip_pkg::CNT_W-1:0] r_reopen_limit;

    logic                      r_pipe_open, n_pipe_open;
    logic                      r_was_enum, n_was_enum;
    logic                      r_busy, n_busy;
    logic [gip_pkg::CNT_W-1:0] r_wait, n_wait;
    logic [gip_pkg::CNT_W-1:0] r_pad_cnt, n_pad_cnt;
    logic [gip_pkg::CNT_W-1:0] r_pipe_cnt, n_pipe_cnt;
    logic                      r_connected, n_connected;
    gip_pkg::t_report          r_report, n_report;
    logic                      issue;
    logic                      opened;

    always_comb begin
        n_pipe_open = r_pipe_open;
        n_was_enum  = i_tick.enumerated;
        n_busy      = r_busy;
        n_wait      = r_wait;
        n_pad_cnt   = r_pad_cnt;
        n_pipe_cnt  = r_pipe_cnt;
        n_connected = r_connected;
        n_report    = r_report;
        issue       = 1'b0;
        opened      = 1'b0;

        if (i_tick.enumerated && !r_was_enum) begin
            if (i_tick.endpoint_found) begin
                n_pipe_open = 1'b1;
                opened      = 1'b1;
                n_busy      = 1'b0;
                n_wait      = '0;
                n_pad_cnt   = r_pad_limit;
                n_connected = 1'b0;
                n_pipe_cnt  = '0;
            end
        end else if (!i_tick.enumerated && r_was_enum) begin
            n_pipe_open = 1'b0;
            n_busy      = 1'b0;
            n_report    = '0;
            n_connected = 1'b0;
        end else if (i_tick.enumerated && r_pipe_open) begin
            if (!r_busy) begin
                issue  = 1'b1;
                n_busy = 1'b1;
                n_wait = '0;
            end else begin
                case (i_tick.xfer_status)
                    gip_pkg::ST_DONE: begin
                        if (i_tick.xfer_length >=
                                gip_pkg::LEN_W'(gip_pkg::MIN_REPORT_BYTES)) begin
                            n_report.buttons = {i_tick.button_high_byte,
                                                i_tick.button_low_byte};
                            n_report.left_trigger  = i_tick.left_trigger_byte;
                            n_report.right_trigger = i_tick.right_trigger_byte;
                            n_report.left_x  = i_tick.left_x_byte;
                            n_report.left_y  = i_tick.left_y_byte;
                            n_report.right_x = i_tick.right_x_byte;
                            n_report.right_y = i_tick.right_y_byte;
                            n_connected = 1'b1;
                            n_pad_cnt   = '0;
                            n_pipe_cnt  = '0;
                        end
                        n_busy = 1'b0;
                    end
                    gip_pkg::ST_NAK, gip_pkg::ST_NOTREADY,
                    gip_pkg::ST_ERROR, gip_pkg::ST_STALL: begin
                        n_busy = 1'b0;
                    end
                    default: begin
                        // pending, and unknown codes treated as pending
                        if (r_wait < r_retry_limit) begin
                            n_wait = r_wait + gip_pkg::CNT_W'(1);
                        end else begin
                            n_busy = 1'b0;
                            n_wait = '0;
                        end
                    end
                endcase
                if (!n_connected) begin
                    if (n_pipe_cnt < r_reopen_limit) begin
                        n_pipe_cnt = n_pipe_cnt + gip_pkg::CNT_W'(1);
                    end else if (i_tick.endpoint_found) begin
                        opened     = 1'b1;
                        n_busy     = 1'b0;
                        n_wait     = '0;
                        n_pipe_cnt = '0;
                    end else begin
                        n_pipe_open = 1'b0;
                        n_busy      = 1'b0;
                    end
                end
            end
        end

        // pad silence watchdog
        if (!i_tick.enumerated) begin
            n_connected = 1'b0;
            n_pad_cnt   = r_pad_limit;
        end else if (n_pad_cnt < r_pad_limit) begin
            n_pad_cnt = n_pad_cnt + gip_pkg::CNT_W'(1);
        end else begin
            n_connected = 1'b0;
        end
    end

    assign o_result.issue_request = issue;
    assign o_result.open_pipe     = opened;
    assign o_result.pad_connected = n_connected;
    assign o_result.report        = n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= gip_pkg::RETRY_LIMIT_RST;
            r_pad_limit    <= gip_pkg::PAD_SILENT_LIMIT_RST;
            r_reopen_limit <= gip_pkg::PIPE_REOPEN_LIMIT_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                gip_pkg::CFG_RETRY_LIMIT:       r_retry_limit  <= i_cfg.data;
                gip_pkg::CFG_PAD_SILENT_LIMIT:  r_pad_limit    <= i_cfg.data;
                gip_pkg::CFG_PIPE_REOPEN_LIMIT: r_reopen_limit <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_open <= 1'b0;
            r_was_enum  <= 1'b0;
            r_busy      <= 1'b0;
            r_wait      <= '0;
            r_pad_cnt   <= '0;
            r_pipe_cnt  <= '0;
            r_connected <= 1'b0;
            r_report    <= '0;
        end else if (i_advance) begin
            r_pipe_open <= n_pipe_open;
            r_was_enum  <= n_was_enum;
            r_busy      <= n_busy;
            r_wait      <= n_wait;
            r_pad_cnt   <= n_pad_cnt;
            r_pipe_cnt  <= n_pipe_cnt;
            r_connected <= n_connected;
            r_report    <= n_report;
        end
    end

endmodule

// ----- rtl/core/gip_out_reg.sv -----
// Result register: holds a result until the receiver takes it.
module gip_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gip_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output gip_pkg::t_result o_result
);

    logic             r_valid;
    gip_pkg::t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- rtl/core/gamepad_interrupt_in_poller_core.sv -----
// Gamepad interrupt-IN poller.
// Input channel (i_in_valid / o_in_stall): one transfer per millisecond tick,
// carrying enumeration, endpoint-found, transfer status, byte count and the
// report bytes. Output channel (o_out_valid / i_out_stall): one result
// transfer per tick: request strobe, pipe-open strobe, connected flag and
// the latest decoded report.
// Path: an accepted tick waits in the input register; as it advances, its
// result is loaded into the result register and shown on the result ports.
// Throughput: one tick per cycle unless the receiver stalls; the whole update
// is a few compares and 16-bit increments between input and result register.
// Stalls: when the receiver stalls, the result register holds and one more
// tick is still taken into the input register; only then does o_in_stall
// rise, and it falls in the cycle the result register drains.
// Reset (i_rst_n low, synchronous): both stages empty, pipe closed, all
// counters and the report zero, limits back to 50 / 300 / 1500.
// Configuration: i_cfg_we with i_cfg_idx 0 retry limit, 1 pad silence
// limit, 2 pipe reopen limit; other indexes are dropped. Write only while
// no tick is in flight.
module gamepad_interrupt_in_poller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [gip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gip_pkg::CNT_W-1:0]         i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_enumerated,
    input  logic                              i_endpoint_found,
    input  logic [gip_pkg::STATUS_W-1:0]      i_xfer_status,
    input  logic [gip_pkg::LEN_W-1:0]         i_xfer_length,
    input  logic [7:0]                        i_button_low_byte,
    input  logic [7:0]                        i_button_high_byte,
    input  logic [7:0]                        i_left_trigger_byte,
    input  logic [7:0]                        i_right_trigger_byte,
    input  logic [7:0]                        i_left_y_byte,
    input  logic [7:0]                        i_left_x_byte,
    input  logic [7:0]                        i_right_y_byte,
    input  logic [7:0]                        i_right_x_byte,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_issue_request,
    output logic                              o_open_pipe,
    output logic                              o_pad_connected,
    output logic [15:0]                       o_buttons,
    output logic [7:0]                        o_left_trigger,
    output logic [7:0]                        o_right_trigger,
    output logic signed [7:0]                 o_left_x,
    output logic signed [7:0]                 o_left_y,
    output logic signed [7:0]                 o_right_x,
    output logic signed [7:0]                 o_right_y
);

    gip_pkg::t_tick   in_tick;
    gip_pkg::t_tick   stage_tick;
    gip_pkg::t_cfg_wr cfg_wr;
    gip_pkg::t_result next_result;
    gip_pkg::t_result out_result;
    logic             advance;
    logic             out_ready;

    // Gather the tick fields into one word for the input stage.
    assign in_tick.enumerated         = i_enumerated;
    assign in_tick.endpoint_found     = i_endpoint_found;
    assign in_tick.xfer_status        = i_xfer_status;
    assign in_tick.xfer_length        = i_xfer_length;
    assign in_tick.button_low_byte    = i_button_low_byte;
    assign in_tick.button_high_byte   = i_button_high_byte;
    assign in_tick.left_trigger_byte  = i_left_trigger_byte;
    assign in_tick.right_trigger_byte = i_right_trigger_byte;
    assign in_tick.left_y_byte        = i_left_y_byte;
    assign in_tick.left_x_byte        = i_left_x_byte;
    assign in_tick.right_y_byte       = i_right_y_byte;
    assign in_tick.right_x_byte       = i_right_x_byte;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    // Stage 1: hold the accepted tick.
    gip_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_tick       (in_tick),
        .i_down_ready (out_ready),
        .o_advance    (advance),
        .o_tick       (stage_tick)
    );

    // Update poller state as the tick advances into the result register.
    gip_tick_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_advance (advance),
        .i_tick    (stage_tick),
        .o_result  (next_result)
    );

    // Stage 2: hold the result until the receiver takes it.
    gip_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (next_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_issue_request = out_result.issue_request;
    assign o_open_pipe     = out_result.open_pipe;
    assign o_pad_connected = out_result.pad_connected;
    assign o_buttons       = out_result.report.buttons;
    assign o_left_trigger  = out_result.report.left_trigger;
    assign o_right_trigger = out_result.report.right_trigger;
    assign o_left_x        = out_result.report.left_x;
    assign o_left_y        = out_result.report.left_y;
    assign o_right_x       = out_result.report.right_x;
    assign o_right_y       = out_result.report.right_y;

endmodule

// ----- rtl/core/gip_checker.sv -----
module gip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_issue_request,
    input logic        o_open_pipe,
    input logic        o_pad_connected,
    input logic [15:0] o_buttons
);

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_buttons) && $stable(o_issue_request)
             && $stable(o_open_pipe) && $stable(o_pad_connected)))
        else $error("stalled result changed");

    // Input stalls only behind a full, stalled result register.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A tick never both issues a request and opens the pipe.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_issue_request && o_open_pipe))
        else $error("request and pipe open in one tick");

    // Opening the pipe always leaves the pad disconnected.
    a_open_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_open_pipe) |-> !o_pad_connected)
        else $error("pipe opened while connected");

endmodule

bind gamepad_interrupt_in_poller_core gip_checker u_gip_checker (.*);

// ----- tb/gamepad_interrupt_in_poller_core_tb.sv -----
module gamepad_interrupt_in_poller_core_tb;

    // Status codes outside the defined set; the poller treats them as pending.
    localparam logic [gip_pkg::STATUS_W-1:0] ST_UNKNOWN_LO = 3'd6;
    localparam logic [gip_pkg::STATUS_W-1:0] ST_UNKNOWN_HI = 3'd7;

    localparam int MAX_REPORT_BYTES = 64;
    localparam int NOISE_PCT        = 8;
    localparam int HOLDOFF_CYCLES   = 80;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTED     = 40;
    localparam int TICK_W           = $bits(gip_pkg::t_tick);

    localparam logic [gip_pkg::LEN_W-1:0] LEN_MIN =
        gip_pkg::LEN_W'(gip_pkg::MIN_REPORT_BYTES);
    localparam logic [gip_pkg::LEN_W-1:0] LEN_SHORT =
        gip_pkg::LEN_W'(gip_pkg::MIN_REPORT_BYTES - 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_we = 1'b0;
    logic [gip_pkg::CFG_IDX_W-1:0] cfg_idx = gip_pkg::CFG_RETRY_LIMIT;
    logic [gip_pkg::CNT_W-1:0]     cfg_data = '0;

    logic           tick_valid = 1'b0;
    logic           tick_stall;
    gip_pkg::t_tick tick_drv = '0;

    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              issue_request;
    logic              open_pipe;
    logic              pad_connected;
    logic [15:0]       buttons;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;

    // Ticks waiting to be offered, and poll results waiting to come out.
    gip_pkg::t_tick   pending_ticks[$];
    gip_pkg::t_result results_due[$];

    int ticks_queued   = 0;
    int ticks_accepted = 0;
    int mismatch_count = 0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int holdoff_requests  = 0;
    int holdoff_served    = 0;
    int holdoff_left      = 0;

    // Generator state: the enumeration level of the random tick stream.
    bit gen_enumerated = 1'b0;

    // Poller shadow state and its copy of the limit registers.
    bit               pipe_up;
    bit               enum_seen;
    bit               req_out;
    bit               pad_linked;
    logic [15:0]      wait_ticks;
    logic [15:0]      pad_quiet;
    logic [15:0]      pipe_quiet;
    gip_pkg::t_report held_report;
    logic [15:0]      lim_retry;
    logic [15:0]      lim_pad_quiet;
    logic [15:0]      lim_reopen;

    gip_pkg::t_result seen_result;
    gip_pkg::t_result due_result;

    gamepad_interrupt_in_poller_core u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (tick_valid),
        .o_in_stall           (tick_stall),
        .i_enumerated         (tick_drv.enumerated),
        .i_endpoint_found     (tick_drv.endpoint_found),
        .i_xfer_status        (tick_drv.xfer_status),
        .i_xfer_length        (tick_drv.xfer_length),
        .i_button_low_byte    (tick_drv.button_low_byte),
        .i_button_high_byte   (tick_drv.button_high_byte),
        .i_left_trigger_byte  (tick_drv.left_trigger_byte),
        .i_right_trigger_byte (tick_drv.right_trigger_byte),
        .i_left_y_byte        (tick_drv.left_y_byte),
        .i_left_x_byte        (tick_drv.left_x_byte),
        .i_right_y_byte       (tick_drv.right_y_byte),
        .i_right_x_byte       (tick_drv.right_x_byte),
        .o_out_valid          (result_valid),
        .i_out_stall          (result_stall),
        .o_issue_request      (issue_request),
        .o_open_pipe          (open_pipe),
        .o_pad_connected      (pad_connected),
        .o_buttons            (buttons),
        .o_left_trigger       (left_trigger),
        .o_right_trigger      (right_trigger),
        .o_left_x             (left_x),
        .o_left_y             (left_y),
        .o_right_x            (right_x),
        .o_right_y            (right_y)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Advance the shadow poller by one tick and return the result it owes.
    function automatic gip_pkg::t_result poller_step(gip_pkg::t_tick t);
        gip_pkg::t_result r;
        r = '0;
        if (t.enumerated && !enum_seen) begin
            // Rising enumeration: open only when the device has an IN endpoint.
            if (t.endpoint_found) begin
                pipe_up     = 1'b1;
                r.open_pipe = 1'b1;
                req_out     = 1'b0;
                wait_ticks  = '0;
                pad_quiet   = lim_pad_quiet;
                pad_linked  = 1'b0;
                pipe_quiet  = '0;
            end
        end else if (!t.enumerated && enum_seen) begin
            // Falling enumeration: close the pipe and drop the report.
            pipe_up     = 1'b0;
            req_out     = 1'b0;
            held_report = '0;
            pad_linked  = 1'b0;
        end else if (t.enumerated && pipe_up) begin
            if (!req_out) begin
                r.issue_request = 1'b1;
                req_out         = 1'b1;
                wait_ticks      = '0;
            end else begin
                case (t.xfer_status)
                    gip_pkg::ST_DONE: begin
                        if (t.xfer_length >= LEN_MIN) begin
                            held_report.buttons       = {t.button_high_byte,
                                                         t.button_low_byte};
                            held_report.left_trigger  = t.left_trigger_byte;
                            held_report.right_trigger = t.right_trigger_byte;
                            held_report.left_x        = t.left_x_byte;
                            held_report.left_y        = t.left_y_byte;
                            held_report.right_x       = t.right_x_byte;
                            held_report.right_y       = t.right_y_byte;
                            pad_linked = 1'b1;
                            pad_quiet  = '0;
                            pipe_quiet = '0;
                        end
                        req_out = 1'b0;
                    end
                    gip_pkg::ST_NAK, gip_pkg::ST_NOTREADY,
                    gip_pkg::ST_ERROR, gip_pkg::ST_STALL: begin
                        req_out = 1'b0;
                    end
                    default: begin
                        // Pending, or an unknown code: wait out the retry limit.
                        if (wait_ticks < lim_retry) begin
                            wait_ticks++;
                        end else begin
                            req_out    = 1'b0;
                            wait_ticks = '0;
                        end
                    end
                endcase
                // Pipe watchdog: reopen a silent pipe, or close it with no endpoint.
                if (!pad_linked) begin
                    if (pipe_quiet < lim_reopen) begin
                        pipe_quiet++;
                    end else if (t.endpoint_found) begin
                        r.open_pipe = 1'b1;
                        req_out     = 1'b0;
                        wait_ticks  = '0;
                        pipe_quiet  = '0;
                    end else begin
                        pipe_up = 1'b0;
                        req_out = 1'b0;
                    end
                end
            end
        end
        // Pad watchdog.
        if (!t.enumerated) begin
            pad_linked = 1'b0;
            pad_quiet  = lim_pad_quiet;
        end else if (pad_quiet < lim_pad_quiet) begin
            pad_quiet++;
        end else begin
            pad_linked = 1'b0;
        end
        enum_seen       = t.enumerated;
        r.pad_connected = pad_linked;
        r.report        = held_report;
        return r;
    endfunction

    function automatic gip_pkg::t_tick tick_of(bit en, bit ep,
                                               logic [gip_pkg::STATUS_W-1:0] st,
                                               logic [gip_pkg::LEN_W-1:0] len);
        gip_pkg::t_tick t;
        t                = TICK_W'({$urandom, $urandom, $urandom});
        t.enumerated     = en;
        t.endpoint_found = ep;
        t.xfer_status    = st;
        t.xfer_length    = len;
        return t;
    endfunction

    function automatic gip_pkg::t_tick filled(gip_pkg::t_tick t, logic [7:0] b);
        gip_pkg::t_tick f;
        f                    = t;
        f.button_low_byte    = b;
        f.button_high_byte   = b;
        f.left_trigger_byte  = b;
        f.right_trigger_byte = b;
        f.left_y_byte        = b;
        f.left_x_byte        = b;
        f.right_y_byte       = b;
        f.right_x_byte       = b;
        return f;
    endfunction

    // Mostly well-formed tick streams: enumeration held with rare drops,
    // endpoint usually present, a weighted mix of transfer outcomes.
    function automatic gip_pkg::t_tick random_tick(int done_pct);
        gip_pkg::t_tick t;
        int             pick;
        t = TICK_W'({$urandom, $urandom, $urandom});
        if ($urandom_range(99) < NOISE_PCT) begin
            return t;
        end
        if (gen_enumerated) begin
            if ($urandom_range(99) < 2) gen_enumerated = 1'b0;
        end else if ($urandom_range(99) < 40) begin
            gen_enumerated = 1'b1;
        end
        t.enumerated     = gen_enumerated;
        t.endpoint_found = ($urandom_range(99) < 92);
        pick = $urandom_range(99);
        if (pick < done_pct) begin
            t.xfer_status = gip_pkg::ST_DONE;
            pick = $urandom_range(99);
            if (pick < 70) begin
                t.xfer_length = gip_pkg::LEN_W'($urandom_range(gip_pkg::MIN_REPORT_BYTES,
                                                               MAX_REPORT_BYTES));
            end else if (pick < 85) begin
                t.xfer_length = gip_pkg::LEN_W'($urandom_range(
                                    gip_pkg::MIN_REPORT_BYTES - 1, 0));
            end else begin
                t.xfer_length = gip_pkg::LEN_W'($urandom_range(MAX_REPORT_BYTES + 1, 127));
            end
        end else if (pick < done_pct + 20) begin
            t.xfer_status = gip_pkg::STATUS_W'($urandom_range(gip_pkg::ST_NAK,
                                                              gip_pkg::ST_STALL));
        end else if (pick < done_pct + 25) begin
            t.xfer_status = gip_pkg::STATUS_W'($urandom_range(ST_UNKNOWN_LO,
                                                              ST_UNKNOWN_HI));
        end else begin
            t.xfer_status = gip_pkg::ST_PENDING;
        end
        return t;
    endfunction

    task automatic queue_tick(gip_pkg::t_tick t);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Block until every queued tick is taken and every result has been checked.
    task automatic wait_drained();
        do @(posedge clk);
        while (ticks_accepted != ticks_queued || results_due.size() != 0);
    endtask

    // Raise the write strobe for one edge; the caller drops it afterwards.
    task automatic write_limit(logic [gip_pkg::CFG_IDX_W-1:0] idx,
                               logic [gip_pkg::CNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            gip_pkg::CFG_RETRY_LIMIT:       lim_retry     = value;
            gip_pkg::CFG_PAD_SILENT_LIMIT:  lim_pad_quiet = value;
            gip_pkg::CFG_PIPE_REOPEN_LIMIT: lim_reopen    = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic run_phase(int n, logic [gip_pkg::CNT_W-1:0] retry,
                             logic [gip_pkg::CNT_W-1:0] pad,
                             logic [gip_pkg::CNT_W-1:0] reopen, int s_idle, int r_idle,
                             int done_pct, bit long_hold);
        write_limit(gip_pkg::CFG_RETRY_LIMIT, retry);
        write_limit(gip_pkg::CFG_PAD_SILENT_LIMIT, pad);
        write_limit(gip_pkg::CFG_PIPE_REOPEN_LIMIT, reopen);
        cfg_we <= 1'b0;
        sender_idle_pct   = s_idle;
        receiver_idle_pct = r_idle;
        repeat (n) queue_tick(random_tick(done_pct));
        // Request a long receiver hold-off once the ticks are queued so the block backs up.
        if (long_hold) holdoff_requests++;
        wait_drained();
    endtask

    // Sender: offer queued ticks, predict each transfer as it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            tick_valid <= 1'b0;
        end else begin
            if (tick_valid && !tick_stall) begin
                results_due.push_back(poller_step(tick_drv));
                ticks_accepted++;
            end
            // Hold a stalled tick; otherwise pick the next one or idle.
            if (!tick_valid || !tick_stall) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    tick_drv   <= pending_ticks.pop_front();
                    tick_valid <= 1'b1;
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk) begin
        if (holdoff_left != 0) begin
            holdoff_left--;
            result_stall <= 1'b1;
        end else if (holdoff_served != holdoff_requests) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES;
            result_stall <= 1'b1;
        end else begin
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            if (mismatch_count < MAX_REPORTED) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            end
            mismatch_count++;
        end
    endtask

    // Monitor: check each result transfer against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            seen_result.issue_request        = issue_request;
            seen_result.open_pipe            = open_pipe;
            seen_result.pad_connected        = pad_connected;
            seen_result.report.buttons       = buttons;
            seen_result.report.left_trigger  = left_trigger;
            seen_result.report.right_trigger = right_trigger;
            seen_result.report.left_x        = left_x;
            seen_result.report.left_y        = left_y;
            seen_result.report.right_x       = right_x;
            seen_result.report.right_y       = right_y;
            if (results_due.size() == 0) begin
                if (mismatch_count < MAX_REPORTED) begin
                    $display("%0t: result with none expected, expected none, got %0h",
                             $time, seen_result);
                end
                mismatch_count++;
            end else begin
                due_result = results_due.pop_front();
                compare_field("issue_request", 16'(due_result.issue_request),
                              16'(seen_result.issue_request));
                compare_field("open_pipe", 16'(due_result.open_pipe),
                              16'(seen_result.open_pipe));
                compare_field("pad_connected", 16'(due_result.pad_connected),
                              16'(seen_result.pad_connected));
                compare_field("buttons", due_result.report.buttons,
                              seen_result.report.buttons);
                compare_field("left_trigger", 16'(due_result.report.left_trigger),
                              16'(seen_result.report.left_trigger));
                compare_field("right_trigger", 16'(due_result.report.right_trigger),
                              16'(seen_result.report.right_trigger));
                compare_field("left_x", 16'(due_result.report.left_x),
                              16'(seen_result.report.left_x));
                compare_field("left_y", 16'(due_result.report.left_y),
                              16'(seen_result.report.left_y));
                compare_field("right_x", 16'(due_result.report.right_x),
                              16'(seen_result.report.right_x));
                compare_field("right_y", 16'(due_result.report.right_y),
                              16'(seen_result.report.right_y));
            end
        end
    end

    initial begin
        // Shadow state matches the block after reset.
        pipe_up       = 1'b0;
        enum_seen     = 1'b0;
        req_out       = 1'b0;
        pad_linked    = 1'b0;
        wait_ticks    = '0;
        pad_quiet     = '0;
        pipe_quiet    = '0;
        held_report   = '0;
        lim_retry     = gip_pkg::RETRY_LIMIT_RST;
        lim_pad_quiet = gip_pkg::PAD_SILENT_LIMIT_RST;
        lim_reopen    = gip_pkg::PIPE_REOPEN_LIMIT_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 35;
        receiver_idle_pct = 66;

        // Directed ticks under the reset limits.
        // Rise without an endpoint: pipe stays closed.
        queue_tick(tick_of(1'b1, 1'b0, gip_pkg::ST_PENDING, 7'd0));
        // Closed pipe while enumerated: a done status is ignored.
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, 7'd20));
        queue_tick(tick_of(1'b0, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        // Proper rise opens the pipe; the next tick issues and ignores status.
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, 7'd64));
        queue_tick(filled(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, LEN_MIN), 8'hFF));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(filled(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, LEN_MIN), 8'h80));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        // Length past the report size still counts as a full report.
        queue_tick(filled(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, 7'd127), 8'h7F));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        // One byte short: ignored, request freed.
        queue_tick(filled(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, LEN_SHORT), 8'h00));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_NAK, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_NOTREADY, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_ERROR, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_STALL, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_PENDING, 7'd0));
        // Unknown codes behave as pending.
        queue_tick(tick_of(1'b1, 1'b1, ST_UNKNOWN_LO, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, ST_UNKNOWN_HI, 7'd0));
        queue_tick(tick_of(1'b1, 1'b1, gip_pkg::ST_DONE, 7'd0));
        // Falling enumeration clears the report.
        queue_tick(tick_of(1'b0, 1'b0, gip_pkg::ST_DONE, 7'd64));
        wait_drained();

        // Random phases over a spread of limits, extremes included.
        run_phase(150, 16'd0, 16'd0, 16'd0, 35, 66, 30, 1'b0);
        run_phase(300, 16'd3, 16'd5, 16'd4, 35, 66, 5, 1'b0);
        run_phase(250, 16'hFFFF, 16'hFFFF, 16'hFFFF, 66, 35, 35, 1'b0);
        run_phase(400, 16'd2, 16'd20, 16'd10, 66, 35, 15, 1'b1);
        run_phase(300, 16'd7, 16'd3, 16'd30, 0, 0, 10, 1'b0);
        run_phase(350, 16'd1, 16'd12, 16'd2, 0, 0, 20, 1'b1);

        // Let any stray result show up before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
